// ===== src/ukt_pkg.sv =====
// ----------------------------------------------------------------------------
// ukt_pkg
// Types and codes shared by the unique key table: request and response
// beats, the stored entry layout, operation and status codes, FSM states.
// ----------------------------------------------------------------------------
package ukt_pkg;

  localparam int CODE_W  = 44;
  localparam int NAME_HW = 64;
  localparam int NAME_MW = 64;
  localparam int NAME_LW = 32;
  localparam int PRICE_W = 32;
  localparam int ENTRY_W = 9;

  // operation codes carried in request.kind
  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_DELETE = 2'd1;
  localparam logic [1:0] KIND_LOOKUP = 2'd2;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_DUP_CODE  = 3'd2,
    ST_DUP_NAME  = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [CODE_W-1:0]  item_code;
    logic [NAME_HW-1:0] name_bytes_high;
    logic [NAME_MW-1:0] name_bytes_mid;
    logic [NAME_LW-1:0] name_bytes_low;
    logic [PRICE_W-1:0] price_cents;
  } request_t;

  typedef struct packed {
    status_t            status;
    logic [PRICE_W-1:0] found_price;
    logic [ENTRY_W-1:0] entry_count;
  } response_t;

  typedef struct packed {
    logic [CODE_W-1:0]  code;
    logic [NAME_HW-1:0] name_high;
    logic [NAME_MW-1:0] name_mid;
    logic [NAME_LW-1:0] name_low;
    logic [PRICE_W-1:0] price;
  } entry_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FIN
  } state_t;

endpackage

// ===== src/unique_key_table_insert_delete_lookup.sv =====
// An accepted start scans every held entry, then the finish state raises
// the registered done strobe; an empty table needs no reads.
// Throughput: one operation at a time; the sequential scan of the entry
// memory, one entry read per cycle, sets the pace. busy falls with done.
// Reset empties the table at once (count cleared); entry memory is not cleared.
// ----------------------------------------------------------------------------
// unique_key_table_insert_delete_lookup
// Insertion-ordered table with unique codes and names. Each operation scans
// the entry memory once; a delete compacts the table during the same scan.
// ----------------------------------------------------------------------------
module unique_key_table_insert_delete_lookup #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  ukt_pkg::request_t   request,
  output logic                done,
  output ukt_pkg::response_t  response
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int EW = ukt_pkg::ENTRY_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  // entry memory, one read and one write port
  ukt_pkg::entry_t mem [TABLE_DEPTH];

  ukt_pkg::state_t   state, state_next;
  ukt_pkg::request_t req;
  logic [CW-1:0]     count;
  logic [CW-1:0]     rd_idx;
  logic              pend;
  logic [AW-1:0]     pend_addr;
  ukt_pkg::entry_t   mem_q;
  logic              code_hit;
  logic              name_hit;
  logic [ukt_pkg::PRICE_W-1:0] hit_price;

  logic              accept;
  logic              rd_en;
  logic              code_eq;
  logic              name_eq;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  ukt_pkg::entry_t   wr_data;
  logic              ins_ok;
  ukt_pkg::entry_t   new_entry;
  ukt_pkg::response_t response_next;

  assign accept  = start && !busy;
  assign rd_en   = (state == ukt_pkg::S_SCAN) && (rd_idx < count);
  assign code_eq = pend && (mem_q.code == req.item_code);
  assign name_eq = pend && (mem_q.name_high == req.name_bytes_high) &&
                   (mem_q.name_mid == req.name_bytes_mid) &&
                   (mem_q.name_low == req.name_bytes_low);
  assign ins_ok  = (req.kind == ukt_pkg::KIND_INSERT) && (count < DEPTH_C) &&
                   !code_hit && !name_hit;

  assign new_entry.code      = req.item_code;
  assign new_entry.name_high = req.name_bytes_high;
  assign new_entry.name_mid  = req.name_bytes_mid;
  assign new_entry.name_low  = req.name_bytes_low;
  assign new_entry.price     = req.price_cents;

  // FSM next state, busy and memory write select
  always_comb begin
    state_next = state;
    busy       = (state != ukt_pkg::S_IDLE);
    wr_en      = 1'b0;
    wr_addr    = pend_addr - AW'(1);
    wr_data    = mem_q;
    case (state)
      ukt_pkg::S_IDLE: begin
        if (start) begin
          state_next = ukt_pkg::S_SCAN;
        end
      end
      ukt_pkg::S_SCAN: begin
        // shift each later entry down one place once the code is found
        if (pend && code_hit && (req.kind == ukt_pkg::KIND_DELETE)) begin
          wr_en = 1'b1;
        end
        if (!rd_en && !pend) begin
          state_next = ukt_pkg::S_FIN;
        end
      end
      ukt_pkg::S_FIN: begin
        // append the new entry at the end of the table
        if (ins_ok) begin
          wr_en   = 1'b1;
          wr_addr = count[AW-1:0];
          wr_data = new_entry;
        end
        state_next = ukt_pkg::S_IDLE;
      end
      default: begin
        state_next = ukt_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ukt_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // memory ports
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q <= mem[rd_idx[AW-1:0]];
    end
  end

  // scan control: read address, pending read data
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else begin
      pend <= rd_en;
    end
    pend_addr <= rd_idx[AW-1:0];
    if (accept) begin
      rd_idx <= '0;
    end else if (rd_en) begin
      rd_idx <= rd_idx + CW'(1);
    end
  end

  // capture request, collect match flags
  always_ff @(posedge clk) begin
    if (accept) begin
      req       <= request;
      code_hit  <= 1'b0;
      name_hit  <= 1'b0;
      hit_price <= '0;
    end else begin
      if (code_eq && !code_hit) begin
        hit_price <= mem_q.price;
      end
      if (code_eq) begin
        code_hit <= 1'b1;
      end
      if (name_eq) begin
        name_hit <= 1'b1;
      end
    end
  end

  // entry count and response beat
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= (state == ukt_pkg::S_FIN);
      if (state == ukt_pkg::S_FIN) begin
        if (ins_ok) begin
          count <= count + CW'(1);
        end else if ((req.kind == ukt_pkg::KIND_DELETE) && code_hit) begin
          count <= count - CW'(1);
        end
      end
    end
  end

  // work out the response from the collected match flags
  always_comb begin
    response_next.status      = ukt_pkg::ST_NOT_FOUND;
    response_next.found_price = '0;
    response_next.entry_count = EW'(count);
    case (req.kind)
      ukt_pkg::KIND_INSERT: begin
        if (count >= DEPTH_C) begin
          response_next.status = ukt_pkg::ST_FULL;
        end else if (code_hit) begin
          response_next.status = ukt_pkg::ST_DUP_CODE;
        end else if (name_hit) begin
          response_next.status = ukt_pkg::ST_DUP_NAME;
        end else begin
          response_next.status      = ukt_pkg::ST_OK;
          response_next.entry_count = EW'(count + CW'(1));
        end
      end
      ukt_pkg::KIND_DELETE: begin
        if (code_hit) begin
          response_next.status      = ukt_pkg::ST_OK;
          response_next.entry_count = EW'(count - CW'(1));
        end
      end
      ukt_pkg::KIND_LOOKUP: begin
        if (code_hit) begin
          response_next.status      = ukt_pkg::ST_OK;
          response_next.found_price = hit_price;
        end
      end
      default: begin
        response_next.status = ukt_pkg::ST_NOT_FOUND;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == ukt_pkg::S_FIN) begin
      response <= response_next;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_C)
    else $error("entry count above table depth");

  a_done_after_fin: assert property (@(posedge clk) disable iff (rst)
    (state == ukt_pkg::S_FIN) |=> done)
    else $error("finish without done strobe");

  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ukt_pkg::S_FIN))
    else $error("done strobe without finish");

  a_shift_after_hit: assert property (@(posedge clk) disable iff (rst)
    (wr_en && (state == ukt_pkg::S_SCAN)) |->
      (code_hit && (req.kind == ukt_pkg::KIND_DELETE)))
    else $error("shift write before code match");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> (rd_idx < DEPTH_C))
    else $error("scan read beyond table");
`endif

endmodule

// ===== tb/catalog_monitor.sv =====
// ----------------------------------------------------------------------------
// catalog_monitor
// Watches the request and response channels of the unique key table. Every
// accepted request beat runs through a local copy of the table to predict
// its response; every done beat is checked, field by field, against the
// oldest prediction still waiting.
// ----------------------------------------------------------------------------
module catalog_monitor #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                busy,
  input  ukt_pkg::request_t   request,
  input  logic                done,
  input  ukt_pkg::response_t  response,
  output int                  mismatches,
  output int                  expected_left
);
  timeunit 1ns;
  timeprecision 1ps;

  import ukt_pkg::*;

  // local copy of the table, kept compact and in insertion order
  entry_t    shelf [TABLE_DEPTH];
  int        held;
  response_t predicted_responses [$];

  // Apply one request to the local table and work out its response.
  task automatic predict_response(input request_t req, output response_t rsp);
    int pos;
    bit name_taken;
    pos = -1;
    name_taken = 1'b0;
    rsp.status = ST_NOT_FOUND;
    rsp.found_price = '0;
    // lowest position wins if a code were ever held twice
    for (int i = 0; i < held; i++) begin
      if (pos < 0 && shelf[i].code == req.item_code) pos = i;
      if (shelf[i].name_high == req.name_bytes_high && shelf[i].name_mid == req.name_bytes_mid &&
          shelf[i].name_low == req.name_bytes_low) name_taken = 1'b1;
    end
    case (req.kind)
      KIND_INSERT: begin
        // full beats duplicate code, which beats duplicate name
        if (held >= TABLE_DEPTH) begin
          rsp.status = ST_FULL;
        end else if (pos >= 0) begin
          rsp.status = ST_DUP_CODE;
        end else if (name_taken) begin
          rsp.status = ST_DUP_NAME;
        end else begin
          shelf[held].code      = req.item_code;
          shelf[held].name_high = req.name_bytes_high;
          shelf[held].name_mid  = req.name_bytes_mid;
          shelf[held].name_low  = req.name_bytes_low;
          shelf[held].price     = req.price_cents;
          held++;
          rsp.status = ST_OK;
        end
      end
      KIND_DELETE: begin
        // close the gap so the order of the rest is kept
        if (pos >= 0) begin
          for (int j = pos; j + 1 < held; j++) shelf[j] = shelf[j + 1];
          held--;
          rsp.status = ST_OK;
        end
      end
      KIND_LOOKUP: begin
        if (pos >= 0) begin
          rsp.found_price = shelf[pos].price;
          rsp.status = ST_OK;
        end
      end
      default: begin
        // unused kind: table untouched, answered as not found
      end
    endcase
    rsp.entry_count = ENTRY_W'(held);
  endtask

  // Check done beats against the oldest prediction, then record new requests.
  always @(posedge clk) begin
    response_t want;
    int        errs;
    errs = 0;
    if (rst) begin
      held = 0;
      predicted_responses.delete();
      mismatches <= 0;
    end else begin
      if (done) begin
        if (predicted_responses.size() == 0) begin
          $error("response beat with no request outstanding");
          errs++;
        end else begin
          want = predicted_responses.pop_front();
          if (response.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, response.status);
            errs++;
          end
          if (response.found_price !== want.found_price) begin
            $error("found_price: expected %0d, got %0d", want.found_price,
                   response.found_price);
            errs++;
          end
          if (response.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count,
                   response.entry_count);
            errs++;
          end
        end
      end
      if (start && !busy) begin
        predict_response(request, want);
        predicted_responses.push_back(want);
      end
      mismatches <= mismatches + errs;
    end
    expected_left <= predicted_responses.size();
  end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives insert, delete and lookup commands into the unique key table: a
// short directed run over the corner cases, then random traffic that fills
// the table to full, churns it and drains it, under varying sender idling.
// The monitor predicts and checks every response; this module reports.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ukt_pkg::*;

  localparam int         DEPTH        = 256;
  localparam int         POOL         = 288;
  localparam int         RANDOM_ITEMS = 1400;
  localparam logic [1:0] KIND_UNUSED  = 2'd3;
  localparam logic [CODE_W-1:0] CODE_TOP = 44'd9999999999999;

  typedef enum int {
    MIX_GROW,
    MIX_BALANCED,
    MIX_DRAIN
  } op_mix_t;

  typedef struct packed {
    logic [NAME_HW-1:0] high;
    logic [NAME_MW-1:0] mid;
    logic [NAME_LW-1:0] low;
  } name_t;

  logic      clk;
  logic      rst;
  logic      start;
  logic      busy;
  request_t  request;
  logic      done;
  response_t response;
  int        mismatches;
  int        expected_left;

  logic [CODE_W-1:0] code_pool [POOL];
  name_t             name_pool [POOL];
  int                fill_cursor;
  int                drain_cursor;
  int                idle_pct;

  unique_key_table_insert_delete_lookup #(
    .TABLE_DEPTH(DEPTH)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .response(response)
  );

  catalog_monitor #(
    .TABLE_DEPTH(DEPTH)
  ) monitor (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .request      (request),
    .done         (done),
    .response     (response),
    .mismatches   (mismatches),
    .expected_left(expected_left)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Draw a code: mostly inside the 13-digit range, sometimes any 44-bit value.
  function automatic logic [CODE_W-1:0] random_code();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    if ($urandom_range(3) != 0) raw = raw % 64'd10000000000000;
    return raw[CODE_W-1:0];
  endfunction

  function automatic request_t compose(logic [1:0] kind, logic [CODE_W-1:0] code, name_t name,
                                       logic [PRICE_W-1:0] price);
    request_t r;
    r.kind            = kind;
    r.item_code       = code;
    r.name_bytes_high = name.high;
    r.name_bytes_mid  = name.mid;
    r.name_bytes_low  = name.low;
    r.price_cents     = price;
    return r;
  endfunction

  // Build one random command; pool codes and names make hits likely.
  function automatic request_t make_request(op_mix_t mix);
    request_t r;
    name_t    junk;
    int       roll;
    int       idx;
    int       ins_pct;
    int       del_pct;
    int       look_pct;
    junk = {$urandom, $urandom, $urandom, $urandom, $urandom};
    r = compose(KIND_INSERT, random_code(), junk, $urandom);
    case (mix)
      MIX_GROW: begin
        ins_pct = 80; del_pct = 5; look_pct = 10;
      end
      MIX_DRAIN: begin
        ins_pct = 10; del_pct = 65; look_pct = 20;
      end
      default: begin
        ins_pct = 35; del_pct = 30; look_pct = 30;
      end
    endcase
    roll = $urandom_range(99);
    idx = $urandom_range(POOL - 1);
    if (roll < ins_pct) begin
      // walk the pool in order so the table can reach full
      if ($urandom_range(99) < 85) begin
        idx = fill_cursor;
        fill_cursor = (fill_cursor + 1) % POOL;
      end
      r.item_code = code_pool[idx];
      if ($urandom_range(9) == 0) idx = $urandom_range(POOL - 1);
      r.name_bytes_high = name_pool[idx].high;
      r.name_bytes_mid  = name_pool[idx].mid;
      r.name_bytes_low  = name_pool[idx].low;
      if ($urandom_range(19) == 0) r.price_cents = $urandom_range(1) ? '1 : '0;
    end else if (roll < ins_pct + del_pct) begin
      r.kind = KIND_DELETE;
      if ($urandom_range(99) < 70) begin
        idx = drain_cursor;
        drain_cursor = (drain_cursor + 1) % POOL;
      end
      if ($urandom_range(9) != 0) r.item_code = code_pool[idx];
    end else if (roll < ins_pct + del_pct + look_pct) begin
      r.kind = KIND_LOOKUP;
      if ($urandom_range(99) < 85) r.item_code = code_pool[idx];
    end else begin
      // noise: unused kind, or an insert with a fresh code and name
      if ($urandom_range(1) == 1) begin
        r.kind = KIND_UNUSED;
        if ($urandom_range(1) == 1) r.item_code = code_pool[idx];
      end
    end
    return r;
  endfunction

  // Present one command and hold it until the block takes it.
  task automatic issue(input request_t r);
    start   <= 1'b1;
    request <= r;
    do @(posedge clk); while (busy);
  endtask

  // Idle the sender now and then; an occasional long gap lets the block go quiet.
  task automatic pause_sender(input int pct);
    int gap;
    if ($urandom_range(99) < pct) begin
      gap = ($urandom_range(9) == 0) ? $urandom_range(300, 5) : $urandom_range(4, 1);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold off until every outstanding response has come back, or the limit runs out.
  task automatic hold_until_settled(input int limit);
    int waited;
    waited = 0;
    start <= 1'b0;
    do begin
      @(posedge clk);
      waited++;
    end while (expected_left != 0 && waited < limit);
  endtask

  task automatic run_directed();
    name_t zeros;
    name_t ones;
    name_t almost;
    name_t word;
    zeros  = '0;
    ones   = '1;
    almost = ones;
    almost.low = 32'hFFFF_FFFE;
    word   = {64'h5445_4C45_5649_5349, 64'h4F4E_0000_0000_0000, 32'h0};
    // empty table
    issue(compose(KIND_LOOKUP, '0, zeros, '0));          pause_sender(idle_pct);
    issue(compose(KIND_DELETE, '0, zeros, '0));          pause_sender(idle_pct);
    // extremes of code, name and price
    issue(compose(KIND_INSERT, '0, zeros, '0));          pause_sender(idle_pct);
    issue(compose(KIND_INSERT, '1, ones, '1));           pause_sender(idle_pct);
    issue(compose(KIND_INSERT, CODE_TOP, word, 32'd12345)); pause_sender(idle_pct);
    // refusals: duplicate code, duplicate name, both (code reported)
    issue(compose(KIND_INSERT, '0, almost, 32'd7));      pause_sender(idle_pct);
    issue(compose(KIND_INSERT, 44'd42, ones, 32'd7));    pause_sender(idle_pct);
    issue(compose(KIND_INSERT, CODE_TOP, ones, 32'd7));  pause_sender(idle_pct);
    // name differing only in the last bytes is a new name
    issue(compose(KIND_INSERT, 44'd42, almost, 32'h8000_0000)); pause_sender(idle_pct);
    // lookups of every entry
    issue(compose(KIND_LOOKUP, '1, zeros, '0));          pause_sender(idle_pct);
    issue(compose(KIND_LOOKUP, '0, ones, '1));           pause_sender(idle_pct);
    issue(compose(KIND_LOOKUP, CODE_TOP, zeros, '0));    pause_sender(idle_pct);
    issue(compose(KIND_LOOKUP, 44'd42, zeros, '0));      pause_sender(idle_pct);
    // unused kind on a held code
    issue(compose(KIND_UNUSED, 44'd42, ones, '1));       pause_sender(idle_pct);
    // delete first, middle and last; check the survivors
    issue(compose(KIND_DELETE, '0, zeros, '0));          pause_sender(idle_pct);
    issue(compose(KIND_LOOKUP, '1, zeros, '0));          pause_sender(idle_pct);
    issue(compose(KIND_DELETE, CODE_TOP, zeros, '0));    pause_sender(idle_pct);
    issue(compose(KIND_LOOKUP, CODE_TOP, zeros, '0));    pause_sender(idle_pct);
    issue(compose(KIND_DELETE, 44'd42, zeros, '0));      pause_sender(idle_pct);
    issue(compose(KIND_DELETE, '0, zeros, '0));          pause_sender(idle_pct);
    // a freed code and name can come back
    issue(compose(KIND_INSERT, '0, zeros, 32'd99));      pause_sender(idle_pct);
    issue(compose(KIND_LOOKUP, '0, zeros, '0));          pause_sender(idle_pct);
  endtask

  // Build pools, reset, run directed then random traffic, report.
  initial begin
    op_mix_t mix;
    rst          = 1'b1;
    start        = 1'b0;
    request      = '0;
    fill_cursor  = 0;
    drain_cursor = 0;
    idle_pct     = 11;
    for (int i = 0; i < POOL; i++) begin
      code_pool[i] = random_code();
      name_pool[i] = {$urandom, $urandom, $urandom, $urandom, $urandom};
      // short names, zero padded
      if (i % 3 == 0) name_pool[i].low = '0;
      if (i % 6 == 0) name_pool[i].mid = '0;
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    run_directed();
    hold_until_settled(2000);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // switch idling profile once the pipe is empty
      if (n == RANDOM_ITEMS / 3) begin
        hold_until_settled(2000);
        idle_pct = 60;
      end
      if (n == 2 * RANDOM_ITEMS / 3) begin
        hold_until_settled(2000);
        idle_pct = 0;
      end
      if (n < 400) mix = MIX_GROW;
      else if (n < 700) mix = MIX_BALANCED;
      else if (n < 1000) mix = MIX_DRAIN;
      else if (n < 1250) mix = MIX_GROW;
      else mix = MIX_BALANCED;
      issue(make_request(mix));
      pause_sender(idle_pct);
    end

    hold_until_settled(2000);
    repeat (300) @(posedge clk);
    if (mismatches == 0 && expected_left == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  // Bound the run well beyond the slowest legal traffic.
  initial begin
    #50_000_000;
    $display("testbench: errors");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/ukt_pkg.sv
src/unique_key_table_insert_delete_lookup.sv
tb/catalog_monitor.sv
tb/testbench.sv
